// ----- rtl/core/lpl_pkg.sv -----
package lpl_pkg;

	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 17;
	localparam int MKUP_W   = 19;
	localparam int DRIVE_W  = 20;
	localparam int COEF_W   = 16;
	localparam int CEIL_W   = 24;
	localparam int LOOK_W   = 10;

	localparam logic [GAIN_W-1:0] UNITY      = 17'd65536;
	localparam logic [CEIL_W-1:0] FULL_SCALE = 24'd8388608;

	localparam logic [2:0] REG_DRIVE    = 3'd0;
	localparam logic [2:0] REG_CEILING  = 3'd1;
	localparam logic [2:0] REG_RELEASE  = 3'd2;
	localparam logic [2:0] REG_MKTARGET = 3'd3;
	localparam logic [2:0] REG_MKCOEF   = 3'd4;
	localparam logic [2:0] REG_LOOK     = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_PEAK,
		ST_DIV,
		ST_GAIN,
		ST_GRD,
		ST_LANE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [CEIL_W-1:0] ceil;
		logic [DRIVE_W-1:0] drive;
		logic [GAIN_W-1:0] dgain;
		logic [MKUP_W-1:0] mkup;
	} lane_ctl_t;

	function automatic logic [MKUP_W-1:0] one_pole(input logic [COEF_W-1:0] c,
			input logic [MKUP_W-1:0] y, input logic [MKUP_W-1:0] t);
		logic [36:0] acc;
		acc = 37'(c) * 37'(y) + (37'd65536 - 37'(c)) * 37'(t) + 37'd32768;
		return MKUP_W'(acc >> 16);
	endfunction

endpackage

// ----- rtl/core/lpl_div.sv -----
module lpl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [40:0] num,
	input  logic [39:0] den,
	output logic        busy,
	output logic [16:0] quot
);
	logic [5:0]  cnt_q;
	logic [40:0] rem_q;
	logic [40:0] num_q;
	logic [16:0] quot_q;
	logic [41:0] trial;

	// only quotients up to 2^17 matter, numerator < 2^40
	assign trial = {rem_q, num_q[40]} - {2'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd41;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			num_q  <= num;
			quot_q <= '0;
		end else if (cnt_q != 6'd0) begin
			num_q <= {num_q[39:0], 1'b0};
			if (!trial[41]) begin
				rem_q  <= trial[40:0];
				quot_q <= {quot_q[15:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[39:0], num_q[40]};
				quot_q <= {quot_q[15:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 6'd0) || start;
	assign quot = quot_q;
endmodule

// ----- rtl/core/lpl_lane.sv -----
module lpl_lane (
	input  logic                  clk,
	input  lpl_pkg::lane_ctl_t    ctl,
	input  logic signed [23:0]    smp,
	output logic signed [23:0]    res
);
	import lpl_pkg::*;

	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [43:0] p1_s1;
	logic [60:0] p2_s2;
	logic [28:0] lim_s3;
	logic [47:0] p3_s4;
	logic [23:0] mag;
	logic [28:0] lim;
	logic [28:0] fin;

	assign mag = smp[23] ? 24'(-smp) : smp;

	always_ff @(posedge clk) begin
		neg_s1 <= smp[23];
		p1_s1  <= 44'(mag) * 44'(ctl.drive);
		neg_s2 <= neg_s1;
		p2_s2  <= 61'(p1_s1) * 61'(ctl.dgain);
		neg_s3 <= neg_s2;
		lim_s3 <= lim;
		neg_s4 <= neg_s3;
		p3_s4  <= 48'(lim_s3) * 48'(ctl.mkup);
	end

	always_comb begin
		logic [60:0] r;
		logic [47:0] q;
		r = (p2_s2 + 61'h80000000) >> 32;
		lim = (r > 61'(ctl.ceil)) ? 29'(ctl.ceil) : 29'(r);
		q = (p3_s4 + 48'd32768) >> 16;
		fin = (q > 48'(ctl.ceil)) ? 29'(ctl.ceil) : 29'(q);
		if (neg_s4) begin
			res = 24'(-fin);
		end else if (fin > 29'd8388607) begin
			res = 24'sd8388607;
		end else begin
			res = 24'(fin);
		end
	end
endmodule

// ----- rtl/core/lookahead_peak_limiter.sv -----
// channel   dir  beat
// s_axis    in   tdata = left_sample, right_sample
// m_axis    out  tdata = left_out, right_out, gain_now (zero filled to 72 bits)
// apb       in   six registers at byte addresses 0..20
// a beat is accepted only while idle, not while the last one is in work; a
// peak over the ceiling has the 41-step restoring divider form ceiling over peak
// output goes valid in OUT after RD, PEAK, DIV if dividing, GAIN, GRD, LANE
// after reset both rings are swept over all MAX_LOOKAHEAD entries
// a waiting output beat holds off input until it is taken
module lookahead_peak_limiter #(
	parameter int MAX_LOOKAHEAD = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // left_sample, right_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // left_out, right_out, gain_now
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lpl_pkg::*;

	localparam int AW = $clog2(MAX_LOOKAHEAD);

	logic [DRIVE_W-1:0] drive_q;
	logic [CEIL_W-1:0]  ceil_reg_q;
	logic [COEF_W-1:0]  rel_q;
	logic [MKUP_W-1:0]  mkt_q;
	logic [COEF_W-1:0]  mkc_q;
	logic [LOOK_W-1:0]  look_q;
	logic [2:0]         ridx;
	logic               wr;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q    <= 20'd65536;
			ceil_reg_q <= 24'd8388608;
			rel_q      <= 16'd65000;
			mkt_q      <= 19'd65536;
			mkc_q      <= 16'd65500;
			look_q     <= 10'd512;
		end else if (wr) begin
			case (ridx)
				REG_DRIVE:    drive_q    <= pwdata[DRIVE_W-1:0];
				REG_CEILING:  ceil_reg_q <= pwdata[CEIL_W-1:0];
				REG_RELEASE:  rel_q      <= pwdata[COEF_W-1:0];
				REG_MKTARGET: mkt_q      <= pwdata[MKUP_W-1:0];
				REG_MKCOEF:   mkc_q      <= pwdata[COEF_W-1:0];
				REG_LOOK:     look_q     <= pwdata[LOOK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_DRIVE:    prdata = 32'(drive_q);
			REG_CEILING:  prdata = 32'(ceil_reg_q);
			REG_RELEASE:  prdata = 32'(rel_q);
			REG_MKTARGET: prdata = 32'(mkt_q);
			REG_MKCOEF:   prdata = 32'(mkc_q);
			REG_LOOK:     prdata = 32'(look_q);
			default:      prdata = '0;
		endcase
	end

	logic [CEIL_W-1:0] ceil;
	logic [AW:0]       look;
	assign ceil = (ceil_reg_q > FULL_SCALE) ? FULL_SCALE : ceil_reg_q;
	always_comb begin
		if (look_q == '0) look = (AW+1)'(1);
		else if (32'(look_q) > MAX_LOOKAHEAD) look = (AW+1)'(MAX_LOOKAHEAD);
		else look = (AW+1)'(look_q);
	end

	// memories
	logic [47:0]       amem [MAX_LOOKAHEAD];
	logic [GAIN_W-1:0] gmem [MAX_LOOKAHEAD];
	logic [47:0]       ard_q;
	logic [GAIN_W-1:0] grd_q;
	logic              awe, gwe, grd;
	logic [AW-1:0]     awa;
	logic [47:0]       awd;
	logic [AW-1:0]     gwa, gra;
	logic [GAIN_W-1:0] gwd;

	state_t st_q, st_d;
	logic [AW-1:0]     pos_q;
	logic [AW:0]       clr_q;
	logic [47:0]       in_q;
	logic [GAIN_W-1:0] lg_q;
	logic [MKUP_W-1:0] mg_q;
	logic [27:0]       peak_q;
	logic [2:0]        lcnt_q;
	logic [47:0]       res_q;
	logic [GAIN_W-1:0] gout_q;
	logic              ov_q;
	logic [GAIN_W-1:0] dg_q;

	logic        dstart, dbusy;
	logic [16:0] quot;

	always_ff @(posedge clk) begin
		if (awe) amem[awa] <= awd;
		ard_q <= amem[pos_q];
		if (gwe) gmem[gwa] <= gwd;
		if (grd) grd_q <= gmem[gra];
	end

	// peak from two lanes of driven magnitude
	logic [23:0] ml, mr;
	logic [43:0] dl, dr;
	logic [27:0] pl, pr;
	assign ml = in_q[23]  ? 24'(-$signed(in_q[23:0]))  : in_q[23:0];
	assign mr = in_q[47]  ? 24'(-$signed(in_q[47:24])) : in_q[47:24];
	assign dl = 44'(ml) * 44'(drive_q);
	assign dr = 44'(mr) * 44'(drive_q);
	assign pl = 28'((dl + 44'd32768) >> 16);
	assign pr = 28'((dr + 44'd32768) >> 16);

	logic [GAIN_W-1:0] target, rel_g;
	assign target = (quot > 17'(UNITY)) ? UNITY : quot;
	assign rel_g  = GAIN_W'(one_pole(rel_q, MKUP_W'(lg_q), MKUP_W'(UNITY)));

	logic [AW:0]   gsum;
	logic [AW-1:0] gpos;
	assign gsum = {1'b0, pos_q} + look;
	assign gpos = (gsum >= (AW+1)'(MAX_LOOKAHEAD)) ?
		AW'(gsum - (AW+1)'(MAX_LOOKAHEAD)) : AW'(gsum);

	lane_ctl_t ctl;
	assign ctl.ceil  = ceil;
	assign ctl.drive = drive_q;
	assign ctl.dgain = dg_q;
	assign ctl.mkup  = mg_q;

	logic signed [23:0] rl, rr;
	lpl_lane u_lane_l (.clk(clk), .ctl(ctl), .smp(ard_q[23:0]),  .res(rl));
	lpl_lane u_lane_r (.clk(clk), .ctl(ctl), .smp(ard_q[47:24]), .res(rr));

	lpl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.num({1'b0, ceil, 16'd0}), .den({12'd0, peak_q}),
		.busy(dbusy), .quot(quot)
	);

	logic sweep;
	assign sweep = (clr_q != (AW+1)'(MAX_LOOKAHEAD));
	assign s_axis_tready = (st_q == ST_IDLE) && !sweep && !(ov_q && !m_axis_tready);

	always_comb begin
		st_d   = st_q;
		awe    = 1'b0;
		awa    = pos_q;
		awd    = in_q;
		gwe    = 1'b0;
		grd    = 1'b0;
		gwa    = pos_q;
		gra    = gpos;
		gwd    = lg_q;
		dstart = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (sweep) begin
					awe = 1'b1;
					awa = clr_q[AW-1:0];
					awd = '0;
					gwe = 1'b1;
					gwa = clr_q[AW-1:0];
					gwd = UNITY;
				end else if (s_axis_tvalid && s_axis_tready) begin
					st_d = ST_RD;
				end
			end
			ST_RD: st_d = ST_PEAK;
			ST_PEAK: begin
				if (peak_q > 28'(ceil) && peak_q != '0) begin
					dstart = 1'b1;
					st_d   = ST_DIV;
				end else begin
					st_d = ST_GAIN;
				end
			end
			ST_DIV: if (!dbusy) st_d = ST_GAIN;
			ST_GAIN: begin
				gwe  = 1'b1;
				st_d = ST_GRD;
			end
			ST_GRD: begin
				grd  = 1'b1;
				st_d = ST_LANE;
			end
			ST_LANE: begin
				awe = 1'b1;
				if (lcnt_q == 3'd4) st_d = ST_OUT;
			end
			ST_OUT: if (!ov_q || m_axis_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	logic [GAIN_W-1:0] newg;
	always_comb begin
		if (st_q == ST_DIV && target < lg_q) newg = target;
		else newg = rel_g;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			pos_q  <= '0;
			clr_q  <= '0;
			lg_q   <= UNITY;
			mg_q   <= MKUP_W'(UNITY);
			lcnt_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_IDLE && sweep) clr_q <= clr_q + 1'b1;
			if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
			case (st_q)
				ST_RD: mg_q <= MKUP_W'(one_pole(mkc_q, mg_q, mkt_q));
				ST_PEAK: if (!(peak_q > 28'(ceil) && peak_q != '0)) lg_q <= rel_g;
				ST_DIV: if (!dbusy) lg_q <= newg;
				ST_LANE: lcnt_q <= lcnt_q + 3'd1;
				ST_OUT: begin
					if (!ov_q || m_axis_tready) begin
						ov_q   <= 1'b1;
						lcnt_q <= '0;
						pos_q  <= (32'(pos_q) == MAX_LOOKAHEAD - 1) ? '0 : pos_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) in_q <= s_axis_tdata;
		if (st_q == ST_RD) peak_q <= (pl > pr) ? pl : pr;
		if (st_q == ST_LANE && lcnt_q == 3'd0) dg_q <= (gpos == pos_q) ? lg_q : grd_q;
		if (st_q == ST_LANE && lcnt_q == 3'd4) begin
			res_q  <= {rr, rl};
			gout_q <= lg_q;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {7'd0, gout_q, res_q};

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
	a_gain_le_unity: assert property (@(posedge clk) disable iff (!arst_n)
		lg_q <= UNITY) else $error("gain above unity");
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && $past(st_q) == ST_OUT) |-> pos_q != $past(pos_q))
		else $error("ring did not advance");
`endif
endmodule
